/* rtl/sle_pkg.sv */
// Shared types and codes for the sorted list engine.
`timescale 1ns / 1ps
`default_nettype none
package sle_pkg;

   localparam int DATA_W   = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READOUT = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_REM_RD,
      S_REM_CHK,
      S_RDO_RD,
      S_RDO_CHK,
      S_RESP
   } state_type;

   // Result of comparing the entry just read against the request value
   typedef struct packed {
      logic less;
      logic equal;
   } cmp_type;

endpackage
`default_nettype wire

/* rtl/sle_table.sv */
// Entry table: one write port, one registered read port and the shared comparator.
`timescale 1ns / 1ps
`default_nettype none
module sle_table #(
   parameter int DEPTH = 16,
   parameter int IW    = 4
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [IW-1:0]                wr_addr,
   input  wire  [sle_pkg::DATA_W-1:0]   wr_data,
   input  wire                          rd_en,
   input  wire  [IW-1:0]                rd_addr,
   input  wire  [sle_pkg::DATA_W-1:0]   key,
   output logic [sle_pkg::DATA_W-1:0]   rd_data,
   output sle_pkg::cmp_type             cmp
);

   logic [sle_pkg::DATA_W-1:0] mem [DEPTH];
   logic [sle_pkg::DATA_W-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // Signed order and equality against the request value
   assign cmp.less  = $signed(rd_data_ff) < $signed(key);
   assign cmp.equal = (rd_data_ff == key);

endmodule
`default_nettype wire

/* rtl/sorted_list_engine.sv */
// Sorted list engine top level: sequencer over the entry table and response register.
//
//   channel | dir | tdata        | tuser      | tlast
//   req_    | in  | value [31:0] | mode [1:0] | -
//   rsp_    | out | item [31:0]  | status[1:0]| last
//
// Insert walks down over the entries at or above the new value; remove walks the
// whole list; readout streams every entry; full or empty give one status response
// and mode 3 is dropped. Each walk step uses the single read port of the entry
// table, whose data is registered before the compare.
// Reset clears the count and sequencer; entries are not cleared.
// A stalled response holds in the output register; a new request is taken
// while it waits, and the next response load waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_engine #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] item
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   sle_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [31:0]         value_ff, value_in;
   logic [1:0]          status_ff, status_in;
   logic                found_ff, found_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_item_ff, rsp_item_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                wr_en, rd_en;
   logic [IW-1:0]       wr_addr, rd_addr;
   logic [31:0]         wr_data, rd_data;
   logic [CW-1:0]       idx_m1;
   logic                slot_free;
   sle_pkg::cmp_type    cmp;

   sle_table #(
      .DEPTH(CAPACITY),
      .IW   (IW)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .key    (value_ff),
      .rd_data(rd_data),
      .cmp    (cmp)
   );

   assign idx_m1    = idx_ff - ONE_C;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      status_ff     <= status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Next state, table access and response loading
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[IW-1:0];
      wr_data       = value_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[IW-1:0];
      req_tready    = 1'b0;

      case (state_ff)
         sle_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               value_in = req_tdata;
               found_in = 1'b0;
               case (req_tuser)
                  sle_pkg::MODE_INSERT: begin
                     if (count_ff == CAP_C) begin
                        status_in = sle_pkg::ST_FULL;
                        state_in  = sle_pkg::S_RESP;
                     end else begin
                        idx_in   = count_ff;
                        state_in = sle_pkg::S_INS_RD;
                     end
                  end
                  sle_pkg::MODE_REMOVE: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        status_in = sle_pkg::ST_EMPTY;
                        state_in  = sle_pkg::S_RESP;
                     end else begin
                        state_in = sle_pkg::S_REM_RD;
                     end
                  end
                  sle_pkg::MODE_READOUT: begin
                     idx_in = '0;
                     if (count_ff == '0) begin
                        status_in = sle_pkg::ST_EMPTY;
                        state_in  = sle_pkg::S_RESP;
                     end else begin
                        state_in = sle_pkg::S_RDO_RD;
                     end
                  end
                  default: begin
                     // unused mode: drop silently
                     state_in = sle_pkg::S_IDLE;
                  end
               endcase
            end
         end

         // Walk down from the top, moving larger-or-equal entries up one slot
         sle_pkg::S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en     = 1'b1;
               wr_addr   = '0;
               wr_data   = value_ff;
               count_in  = count_ff + ONE_C;
               status_in = sle_pkg::ST_OK;
               state_in  = sle_pkg::S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_m1[IW-1:0];
               state_in = sle_pkg::S_INS_CHK;
            end
         end

         sle_pkg::S_INS_CHK: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            if (cmp.less) begin
               wr_data   = value_ff;
               count_in  = count_ff + ONE_C;
               status_in = sle_pkg::ST_OK;
               state_in  = sle_pkg::S_RESP;
            end else begin
               wr_data  = rd_data;
               idx_in   = idx_m1;
               state_in = sle_pkg::S_INS_RD;
            end
         end

         // Walk up, find first match, then pull later entries down one slot
         sle_pkg::S_REM_RD: begin
            if (idx_ff == count_ff) begin
               if (found_ff) begin
                  count_in  = count_ff - ONE_C;
                  status_in = sle_pkg::ST_OK;
               end else begin
                  status_in = sle_pkg::ST_NOT_FOUND;
               end
               // Park the index inside the shrunken list
               idx_in   = '0;
               state_in = sle_pkg::S_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff[IW-1:0];
               state_in = sle_pkg::S_REM_CHK;
            end
         end

         sle_pkg::S_REM_CHK: begin
            if (found_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_m1[IW-1:0];
               wr_data = rd_data;
            end else if (cmp.equal) begin
               found_in = 1'b1;
            end
            idx_in   = idx_ff + ONE_C;
            state_in = sle_pkg::S_REM_RD;
         end

         // Stream every entry out in order
         sle_pkg::S_RDO_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff[IW-1:0];
            state_in = sle_pkg::S_RDO_CHK;
         end

         sle_pkg::S_RDO_CHK: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = rd_data;
               rsp_status_in = sle_pkg::ST_OK;
               rsp_last_in   = (idx_ff == count_ff - ONE_C);
               if (idx_ff == count_ff - ONE_C) begin
                  state_in = sle_pkg::S_IDLE;
               end else begin
                  idx_in   = idx_ff + ONE_C;
                  state_in = sle_pkg::S_RDO_RD;
               end
            end
         end

         // Single status response
         sle_pkg::S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '0;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
               state_in      = sle_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sle_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("count exceeds capacity");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= count_ff)
      else $error("walk index beyond stored entries");

   a_count_only_on_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sle_pkg::S_INS_RD && state_ff != sle_pkg::S_INS_CHK &&
       state_ff != sle_pkg::S_REM_RD) |=> $stable(count_ff))
      else $error("count changed outside an insert or remove");

   a_mid_readout_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == sle_pkg::ST_OK))
      else $error("non-final response carries an error status");
`endif

endmodule
`default_nettype wire
